// File: rtl/sm83_block0_instruction_unit_defines.svh
// ---------------------------------------------------------------------------
// sm83 block-0 instruction unit assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef SM83_BLOCK0_INSTRUCTION_UNIT_DEFINES_SVH
`define SM83_BLOCK0_INSTRUCTION_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SM83_B0_CHECK(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sm83_b0 check failed");
`define SM83_B0_CHECK_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sm83_b0 sequence check failed");
`else
`define SM83_B0_CHECK(name, prop)
`define SM83_B0_CHECK_NEXT(name, ante, cons)
`endif
`endif

// File: rtl/sm83_b0_pkg.sv
// ---------------------------------------------------------------------------
// sm83 block-0 package
// opcode codes, decoded transaction type and arithmetic constants
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sm83_b0_pkg;

   localparam logic [5:0] OP_NOP       = 6'h00;
   localparam logic [5:0] OP_LD_A16_SP = 6'h08;
   localparam logic [5:0] OP_STOP      = 6'h10;
   localparam logic [5:0] OP_JR        = 6'h18;

   localparam logic [2:0] R8_IND_HL = 3'd6;
   localparam logic [2:0] R8_ACC    = 3'd7;

   localparam logic [1:0] RP_BC = 2'd0;
   localparam logic [1:0] RP_DE = 2'd1;
   localparam logic [1:0] RP_HL = 2'd2;
   localparam logic [1:0] RP_SP = 2'd3;

   localparam logic [1:0] CC_NZ = 2'd0;
   localparam logic [1:0] CC_Z  = 2'd1;
   localparam logic [1:0] CC_NC = 2'd2;
   localparam logic [1:0] CC_C  = 2'd3;

   localparam logic [2:0] ACC_RLCA = 3'd0;
   localparam logic [2:0] ACC_RRCA = 3'd1;
   localparam logic [2:0] ACC_RLA  = 3'd2;
   localparam logic [2:0] ACC_RRA  = 3'd3;
   localparam logic [2:0] ACC_DAA  = 3'd4;
   localparam logic [2:0] ACC_CPL  = 3'd5;
   localparam logic [2:0] ACC_SCF  = 3'd6;
   localparam logic [2:0] ACC_CCF  = 3'd7;

   localparam logic [7:0] DAA_LIMIT   = 8'h99;
   localparam logic [7:0] DAA_ADJ_HI  = 8'h60;
   localparam logic [7:0] DAA_ADJ_LO  = 8'h06;
   localparam logic [3:0] DAA_DIGIT   = 4'h9;

   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   typedef enum logic [3:0] {
      KIND_NOP,
      KIND_STORE_SP,
      KIND_JR,
      KIND_LD16_IMM,
      KIND_ADD_HL,
      KIND_STORE_IND,
      KIND_LOAD_IND,
      KIND_INCDEC16,
      KIND_INCDEC8,
      KIND_LD8_IMM,
      KIND_ACC_OP
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] pc_len;
      logic [1:0] rp;
      logic [2:0] r8;
      logic       dec;
      logic       jr_always;
      logic [7:0] imm_low;
      logic [7:0] imm_high;
      logic [7:0] mem_data;
   } dec_item_type;

endpackage

`default_nettype wire

// File: rtl/sm83_block0_instruction_unit.sv
// an accepted transaction enters the queue, then executes into the result register
// throughput: one instruction per cycle while rsp_stall is low; LD (a16),SP gives two results
// the execute stage's single register-file update per cycle sets that rate
// a two-entry queue decouples request acceptance from result stalls
// reset: synchronous; register file, queue count and pointers and result valid clear to zero
// ---------------------------------------------------------------------------
// sm83 block-0 instruction unit
// top level: decoder, decoded transaction queue and execute stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sm83_block0_instruction_unit_defines.svh"

module sm83_block0_instruction_unit
   import sm83_b0_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [5:0]  req_cmd,
   input  wire logic [7:0]  req_imm_low,
   input  wire logic [7:0]  req_imm_high,
   input  wire logic [7:0]  req_mem_read_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_write_enable,
   output logic [15:0]      rsp_write_address,
   output logic [7:0]       rsp_write_data,
   output logic [15:0]      rsp_read_address,
   output logic             rsp_last_result,
   output logic [15:0]      rsp_pc_out,
   output logic [15:0]      rsp_sp_out,
   output logic [15:0]      rsp_bc_out,
   output logic [15:0]      rsp_de_out,
   output logic [15:0]      rsp_hl_out,
   output logic [7:0]       rsp_acc_out,
   output logic [7:0]       rsp_flags_out
);

   dec_item_type dec_item;
   dec_item_type head_item;
   logic         queue_full;
   logic         head_valid;
   logic         head_pop;
   logic         push;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   sm83_b0_decode u_decode (
      .cmd           (req_cmd),
      .imm_low       (req_imm_low),
      .imm_high      (req_imm_high),
      .mem_read_data (req_mem_read_data),
      .item          (dec_item)
   );

   sm83_b0_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (dec_item),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (head_pop)
   );

   sm83_b0_exec u_exec (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (head_valid),
      .item              (head_item),
      .item_pop          (head_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_read_address  (rsp_read_address),
      .rsp_last_result   (rsp_last_result),
      .rsp_pc_out        (rsp_pc_out),
      .rsp_sp_out        (rsp_sp_out),
      .rsp_bc_out        (rsp_bc_out),
      .rsp_de_out        (rsp_de_out),
      .rsp_hl_out        (rsp_hl_out),
      .rsp_acc_out       (rsp_acc_out),
      .rsp_flags_out     (rsp_flags_out)
   );

   // first half of a two-result transaction is always followed by its last half
   `SM83_B0_CHECK_NEXT(a_second_follows, rsp_valid && !rsp_stall && !rsp_last_result, rsp_valid && rsp_last_result)
   // the first half carries the low stack byte write and no read
   `SM83_B0_CHECK(a_first_is_write, rsp_valid && !rsp_last_result |-> rsp_write_enable && rsp_read_address == 16'd0)
   // no write means zero address and data
   `SM83_B0_CHECK(a_idle_write_zero, rsp_valid && !rsp_write_enable |-> rsp_write_address == 16'd0 && rsp_write_data == 8'd0)

endmodule

`default_nettype wire

// File: rtl/sm83_b0_decode.sv
// ---------------------------------------------------------------------------
// sm83 block-0 decoder
// classifies an incoming opcode into an operation kind and operand fields
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sm83_b0_decode
   import sm83_b0_pkg::*;
(
   input  wire logic [5:0]   cmd,
   input  wire logic [7:0]   imm_low,
   input  wire logic [7:0]   imm_high,
   input  wire logic [7:0]   mem_read_data,
   output dec_item_type      item
);

   always_comb begin
      item           = '0;
      item.kind      = KIND_NOP;
      item.pc_len    = 2'd1;
      item.rp        = cmd[5:4];
      item.r8        = cmd[5:3];
      item.imm_low   = imm_low;
      item.imm_high  = imm_high;
      item.mem_data  = mem_read_data;
      unique case (cmd[2:0])
         3'd0: begin
            if (cmd == OP_LD_A16_SP) begin
               item.kind   = KIND_STORE_SP;
               item.pc_len = 2'd3;
            end else if (cmd == OP_STOP) begin
               item.pc_len = 2'd2;
            end else if (cmd >= OP_JR) begin
               item.kind      = KIND_JR;
               item.pc_len    = 2'd2;
               item.jr_always = (cmd == OP_JR);
            end
         end
         3'd1: begin
            if (cmd[3]) begin
               item.kind = KIND_ADD_HL;
            end else begin
               item.kind   = KIND_LD16_IMM;
               item.pc_len = 2'd3;
            end
         end
         3'd2: item.kind = cmd[3] ? KIND_LOAD_IND : KIND_STORE_IND;
         3'd3: begin
            item.kind = KIND_INCDEC16;
            item.dec  = cmd[3];
         end
         3'd4, 3'd5: begin
            item.kind = KIND_INCDEC8;
            item.dec  = cmd[0];
         end
         3'd6: begin
            item.kind   = KIND_LD8_IMM;
            item.pc_len = 2'd2;
         end
         3'd7: item.kind = KIND_ACC_OP;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/sm83_b0_queue.sv
// ---------------------------------------------------------------------------
// sm83 block-0 decoded transaction queue
// two-entry fifo between the decoder and the execute stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sm83_b0_queue
   import sm83_b0_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire dec_item_type push_item,
   output logic        full,
   output logic        head_valid,
   output dec_item_type head_item,
   input  wire logic   pop
);

   dec_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sm83_b0_exec.sv
// ---------------------------------------------------------------------------
// sm83 block-0 execute stage
// register file, combinational execution and the result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sm83_b0_exec
   import sm83_b0_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    item_valid,
   input  wire dec_item_type item,
   output logic         item_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic         rsp_write_enable,
   output logic [15:0]  rsp_write_address,
   output logic [7:0]   rsp_write_data,
   output logic [15:0]  rsp_read_address,
   output logic         rsp_last_result,
   output logic [15:0]  rsp_pc_out,
   output logic [15:0]  rsp_sp_out,
   output logic [15:0]  rsp_bc_out,
   output logic [15:0]  rsp_de_out,
   output logic [15:0]  rsp_hl_out,
   output logic [7:0]   rsp_acc_out,
   output logic [7:0]   rsp_flags_out
);

   logic [15:0] pc_ff, pc_in;
   logic [15:0] sp_ff, sp_in;
   logic [15:0] bc_ff, bc_in;
   logic [15:0] de_ff, de_in;
   logic [15:0] hl_ff, hl_in;
   logic [7:0]  acc_ff, acc_in;
   logic [3:0]  flag_ff, flag_in;

   logic        valid_ff, valid_in;
   logic        second_ff, second_in;
   logic [15:0] second_addr_ff, second_addr_in;
   logic [7:0]  second_data_ff, second_data_in;
   logic        we_ff, we_in;
   logic [15:0] wa_ff, wa_in;
   logic [7:0]  wd_ff, wd_in;
   logic [15:0] ra_ff, ra_in;
   logic        last_ff, last_in;

   logic        advance;
   logic [15:0] imm16;
   logic [15:0] rp_val;
   logic [15:0] adr;
   logic [16:0] sum17;
   logic [12:0] half13;
   logic [7:0]  old8;
   logic [7:0]  nv8;
   logic [7:0]  adj;
   logic        cond;
   logic        carry;
   logic [15:0] w16;
   logic        wr16;
   logic [7:0]  w8;
   logic        wr8;

   assign advance  = !valid_ff || !rsp_stall;
   assign item_pop = advance && !second_ff && item_valid;
   assign imm16    = {item.imm_high, item.imm_low};

   always_comb begin
      unique case (item.rp)
         RP_BC: rp_val = bc_ff;
         RP_DE: rp_val = de_ff;
         RP_HL: rp_val = hl_ff;
         RP_SP: rp_val = sp_ff;
      endcase
      unique case (item.r8)
         3'd0:      old8 = bc_ff[15:8];
         3'd1:      old8 = bc_ff[7:0];
         3'd2:      old8 = de_ff[15:8];
         3'd3:      old8 = de_ff[7:0];
         3'd4:      old8 = hl_ff[15:8];
         3'd5:      old8 = hl_ff[7:0];
         R8_IND_HL: old8 = item.mem_data;
         R8_ACC:    old8 = acc_ff;
      endcase
      unique case (item.r8[1:0])
         CC_NZ: cond = !flag_ff[FLAG_Z];
         CC_Z:  cond = flag_ff[FLAG_Z];
         CC_NC: cond = !flag_ff[FLAG_C];
         CC_C:  cond = flag_ff[FLAG_C];
      endcase
   end

   always_comb begin
      pc_in          = pc_ff;
      sp_in          = sp_ff;
      bc_in          = bc_ff;
      de_in          = de_ff;
      hl_in          = hl_ff;
      acc_in         = acc_ff;
      flag_in        = flag_ff;
      valid_in       = valid_ff;
      second_in      = second_ff;
      second_addr_in = second_addr_ff;
      second_data_in = second_data_ff;
      we_in          = we_ff;
      wa_in          = wa_ff;
      wd_in          = wd_ff;
      ra_in          = ra_ff;
      last_in        = last_ff;
      adr            = item.rp[1] ? hl_ff : rp_val;
      sum17          = {1'b0, hl_ff} + {1'b0, rp_val};
      half13         = {1'b0, hl_ff[11:0]} + {1'b0, rp_val[11:0]};
      nv8            = item.dec ? (old8 - 8'd1) : (old8 + 8'd1);
      adj            = '0;
      carry          = flag_ff[FLAG_C];
      w16            = '0;
      wr16           = 1'b0;
      w8             = '0;
      wr8            = 1'b0;

      if (advance) begin
         if (second_ff) begin
            valid_in  = 1'b1;
            second_in = 1'b0;
            we_in     = 1'b1;
            wa_in     = second_addr_ff;
            wd_in     = second_data_ff;
            ra_in     = '0;
            last_in   = 1'b1;
         end else if (item_valid) begin
            valid_in = 1'b1;
            we_in    = 1'b0;
            wa_in    = '0;
            wd_in    = '0;
            ra_in    = '0;
            last_in  = 1'b1;
            pc_in    = pc_ff + {14'd0, item.pc_len};
            unique case (item.kind)
               KIND_NOP: begin
               end
               KIND_STORE_SP: begin
                  we_in          = 1'b1;
                  wa_in          = imm16;
                  wd_in          = sp_ff[7:0];
                  last_in        = 1'b0;
                  second_in      = 1'b1;
                  second_addr_in = imm16 + 16'd1;
                  second_data_in = sp_ff[15:8];
               end
               KIND_JR: begin
                  if (item.jr_always || cond) begin
                     pc_in = pc_ff + {14'd0, item.pc_len}
                           + {{8{item.imm_low[7]}}, item.imm_low};
                  end
               end
               KIND_LD16_IMM: begin
                  w16  = imm16;
                  wr16 = 1'b1;
               end
               KIND_ADD_HL: begin
                  hl_in   = sum17[15:0];
                  flag_in = {flag_ff[FLAG_Z], 1'b0, half13[12], sum17[16]};
               end
               KIND_STORE_IND, KIND_LOAD_IND: begin
                  if (item.kind == KIND_LOAD_IND) begin
                     ra_in  = adr;
                     acc_in = item.mem_data;
                  end else begin
                     we_in = 1'b1;
                     wa_in = adr;
                     wd_in = acc_ff;
                  end
                  if (item.rp == RP_HL) begin
                     hl_in = hl_ff + 16'd1;
                  end else if (item.rp == RP_SP) begin
                     hl_in = hl_ff - 16'd1;
                  end
               end
               KIND_INCDEC16: begin
                  w16  = item.dec ? (rp_val - 16'd1) : (rp_val + 16'd1);
                  wr16 = 1'b1;
               end
               KIND_INCDEC8: begin
                  flag_in = {nv8 == 8'd0, item.dec,
                             item.dec ? (old8[3:0] == 4'h0) : (old8[3:0] == 4'hF),
                             flag_ff[FLAG_C]};
                  if (item.r8 == R8_IND_HL) begin
                     ra_in = hl_ff;
                     we_in = 1'b1;
                     wa_in = hl_ff;
                     wd_in = nv8;
                  end else begin
                     w8  = nv8;
                     wr8 = 1'b1;
                  end
               end
               KIND_LD8_IMM: begin
                  if (item.r8 == R8_IND_HL) begin
                     we_in = 1'b1;
                     wa_in = hl_ff;
                     wd_in = item.imm_low;
                  end else begin
                     w8  = item.imm_low;
                     wr8 = 1'b1;
                  end
               end
               KIND_ACC_OP: begin
                  unique case (item.r8)
                     ACC_RLCA: begin
                        acc_in  = {acc_ff[6:0], acc_ff[7]};
                        flag_in = {3'b000, acc_ff[7]};
                     end
                     ACC_RRCA: begin
                        acc_in  = {acc_ff[0], acc_ff[7:1]};
                        flag_in = {3'b000, acc_ff[0]};
                     end
                     ACC_RLA: begin
                        acc_in  = {acc_ff[6:0], flag_ff[FLAG_C]};
                        flag_in = {3'b000, acc_ff[7]};
                     end
                     ACC_RRA: begin
                        acc_in  = {flag_ff[FLAG_C], acc_ff[7:1]};
                        flag_in = {3'b000, acc_ff[0]};
                     end
                     ACC_DAA: begin
                        if (flag_ff[FLAG_N]) begin
                           if (flag_ff[FLAG_H]) adj = adj | DAA_ADJ_LO;
                           if (flag_ff[FLAG_C]) adj = adj | DAA_ADJ_HI;
                           acc_in = acc_ff - adj;
                        end else begin
                           if (flag_ff[FLAG_H] || (acc_ff[3:0] > DAA_DIGIT)) begin
                              adj = adj | DAA_ADJ_LO;
                           end
                           if (flag_ff[FLAG_C] || (acc_ff > DAA_LIMIT)) begin
                              adj   = adj | DAA_ADJ_HI;
                              carry = 1'b1;
                           end else begin
                              carry = 1'b0;
                           end
                           acc_in = acc_ff + adj;
                        end
                        flag_in = {acc_in == 8'd0, flag_ff[FLAG_N], 1'b0, carry};
                     end
                     ACC_CPL: begin
                        acc_in  = ~acc_ff;
                        flag_in = {flag_ff[FLAG_Z], 2'b11, flag_ff[FLAG_C]};
                     end
                     ACC_SCF: flag_in = {flag_ff[FLAG_Z], 3'b001};
                     ACC_CCF: flag_in = {flag_ff[FLAG_Z], 2'b00, ~flag_ff[FLAG_C]};
                  endcase
               end
               default: begin
               end
            endcase

            if (wr16) begin
               unique case (item.rp)
                  RP_BC: bc_in = w16;
                  RP_DE: de_in = w16;
                  RP_HL: hl_in = w16;
                  RP_SP: sp_in = w16;
               endcase
            end
            if (wr8) begin
               unique case (item.r8)
                  3'd0:      bc_in = {w8, bc_ff[7:0]};
                  3'd1:      bc_in = {bc_ff[15:8], w8};
                  3'd2:      de_in = {w8, de_ff[7:0]};
                  3'd3:      de_in = {de_ff[15:8], w8};
                  3'd4:      hl_in = {w8, hl_ff[7:0]};
                  3'd5:      hl_in = {hl_ff[15:8], w8};
                  R8_IND_HL: begin
                  end
                  R8_ACC:    acc_in = w8;
               endcase
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         sp_ff     <= '0;
         bc_ff     <= '0;
         de_ff     <= '0;
         hl_ff     <= '0;
         acc_ff    <= '0;
         flag_ff   <= '0;
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         pc_ff     <= pc_in;
         sp_ff     <= sp_in;
         bc_ff     <= bc_in;
         de_ff     <= de_in;
         hl_ff     <= hl_in;
         acc_ff    <= acc_in;
         flag_ff   <= flag_in;
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      second_addr_ff <= second_addr_in;
      second_data_ff <= second_data_in;
      we_ff          <= we_in;
      wa_ff          <= wa_in;
      wd_ff          <= wd_in;
      ra_ff          <= ra_in;
      last_ff        <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_write_enable  = we_ff;
   assign rsp_write_address = wa_ff;
   assign rsp_write_data    = wd_ff;
   assign rsp_read_address  = ra_ff;
   assign rsp_last_result   = last_ff;
   assign rsp_pc_out        = pc_ff;
   assign rsp_sp_out        = sp_ff;
   assign rsp_bc_out        = bc_ff;
   assign rsp_de_out        = de_ff;
   assign rsp_hl_out        = hl_ff;
   assign rsp_acc_out       = acc_ff;
   assign rsp_flags_out     = {flag_ff, 4'h0};

endmodule

`default_nettype wire
